FILE: sv/bfdh_pkg.sv
// Shared types and constants for the double-hash Bloom filter engine.
package bfdh_pkg;

  localparam int HASH_W       = 32;
  localparam int BIT_LEN_W    = 17;
  localparam int HASH_COUNT_W = 5;
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_ADDR_W   = 3;
  localparam int IN_TDATA_W   = 2 * HASH_W;
  localparam int OUT_TDATA_W  = 8;
  localparam int DIV_STEPS    = HASH_W;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
  localparam int BYTE_SHIFT   = 3;
  localparam int BIT_SEL_W    = 3;

  localparam logic [BIT_LEN_W-1:0]    BIT_LEN_RST    = BIT_LEN_W'(65536);
  localparam logic [HASH_COUNT_W-1:0] HASH_COUNT_RST = HASH_COUNT_W'(7);

  typedef enum logic [0:0] {
    REG_BIT_LEN    = 1'b0,
    REG_HASH_COUNT = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_SETUP,
    ST_READ,
    ST_CHECK,
    ST_RESULT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic clr_wr;
    logic load;
    logic div_step;
    logic setup;
    logic rd;
    logic chk;
    logic out_set;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic div_last;
    logic n_zero;
    logic probe_last;
    logic bit_set;
    logic op_add;
    logic out_free;
  } dp_sts_t;

endpackage

FILE: sv/bfdh_rem.sv
// Bit-serial remainder unit: a, b and 2^32-1 modulo m, one bit per cycle while step is high.
module bfdh_rem
  import bfdh_pkg::*;
#(
  parameter int MW = 17,
  parameter int IW = 16
) (
  input  logic              clk,
  input  logic              start,
  input  logic              step,
  input  logic [HASH_W-1:0] a,
  input  logic [HASH_W-1:0] b,
  input  logic [MW-1:0]     m,
  output logic [IW-1:0]     am,
  output logic [IW-1:0]     bm,
  output logic [IW-1:0]     dm
);

  logic [HASH_W-1:0] dvd_r [2];
  logic [HASH_W-1:0] dvd_nxt [2];
  logic [IW-1:0]     rem_r [3];
  logic [IW-1:0]     rem_nxt [3];

  always_comb begin
    logic [IW:0] t;
    logic        bit_in;
    for (int k = 0; k < 3; k++) begin
      bit_in = (k < 2) ? dvd_r[k % 2][HASH_W-1] : 1'b1;
      t = {rem_r[k], bit_in};
      if (t >= (IW+1)'(m)) begin
        rem_nxt[k] = IW'(t - (IW+1)'(m));
      end else begin
        rem_nxt[k] = IW'(t);
      end
    end
    for (int k = 0; k < 2; k++) begin
      dvd_nxt[k] = {dvd_r[k][HASH_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r[0] <= a;
      dvd_r[1] <= b;
      for (int k = 0; k < 3; k++) begin
        rem_r[k] <= '0;
      end
    end else if (step) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign am = rem_r[0];
  assign bm = rem_r[1];
  assign dm = rem_r[2];

endmodule

FILE: sv/bfdh_datapath.sv
// Datapath: item registers, index stepping, byte bit store and result register.
module bfdh_datapath
  import bfdh_pkg::*;
#(
  parameter int FILTER_BITS = 65536,
  parameter int MAX_HASHES  = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ctrl_cmd_t               cmd,
  output dp_sts_t                 sts,
  input  logic [BIT_LEN_W-1:0]    bit_len,
  input  logic [HASH_COUNT_W-1:0] hash_count,
  input  logic                    in_op,
  input  logic [HASH_W-1:0]       in_hash_a,
  input  logic [HASH_W-1:0]       in_hash_b,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [OUT_TDATA_W-1:0]  out_tdata
);

  localparam int MW          = $clog2(FILTER_BITS + 1);
  localparam int IW          = $clog2(FILTER_BITS);
  localparam int SW          = IW + 2;
  localparam int CW          = $clog2(MAX_HASHES + 1);
  localparam int STORE_BYTES = (FILTER_BITS + 7) / 8;
  localparam int AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

  logic [MW-1:0]     m_eff;
  logic [CW-1:0]     n_eff;
  logic [MW-1:0]     m_r;
  logic [CW-1:0]     n_r;
  logic              op_r;
  logic [HASH_W-1:0] a_r;
  logic [HASH_W-1:0] b_r;
  logic [HASH_W-1:0] h_r;
  logic [IW-1:0]     r_r;
  logic [IW-1:0]     r_nxt;
  logic [IW-1:0]     c_r;
  logic [IW-1:0]     c_nxt;
  logic [CW-1:0]     i_r;
  logic [CW-1:0]     i_inc;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [AW-1:0]     clr_addr_r;
  logic              pres_r;
  logic              out_valid_r;
  logic              out_data_r;
  logic [IW-1:0]     am;
  logic [IW-1:0]     bm;
  logic [IW-1:0]     dm;
  logic [HASH_W:0]   hsum;
  logic [SW-1:0]     s_raw;
  logic [7:0]        rd_data_r;
  logic [7:0]        bit_mask;
  logic [AW-1:0]     probe_addr;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [7:0]        mem_wdata;

  logic [7:0] mem [STORE_BYTES];

  // clamp the configuration to the legal range
  always_comb begin
    if (bit_len == '0) begin
      m_eff = MW'(1);
    end else if (32'(bit_len) > FILTER_BITS) begin
      m_eff = MW'(FILTER_BITS);
    end else begin
      m_eff = MW'(bit_len);
    end
    if (32'(hash_count) > MAX_HASHES) begin
      n_eff = CW'(MAX_HASHES);
    end else begin
      n_eff = CW'(hash_count);
    end
  end

  bfdh_rem #(
    .MW(MW),
    .IW(IW)
  ) u_rem (
    .clk  (clk),
    .start(cmd.load),
    .step (cmd.div_step),
    .a    (in_hash_a),
    .b    (in_hash_b),
    .m    (m_r),
    .am   (am),
    .bm   (bm),
    .dm   (dm)
  );

  // 2^32 mod m from (2^32-1) mod m
  assign c_nxt = (MW'(dm) + MW'(1) == m_r) ? '0 : IW'(dm + IW'(1));

  // next index: r + (b mod m) - (2^32 mod m on carry), folded back into [0, m)
  assign hsum = {1'b0, h_r} + {1'b0, b_r};
  assign s_raw = SW'(r_r) + SW'(bm) - (hsum[HASH_W] ? SW'(c_r) : SW'(0));

  always_comb begin
    if (s_raw[SW-1]) begin
      r_nxt = IW'(s_raw + SW'(m_r));
    end else if (s_raw >= SW'(m_r)) begin
      r_nxt = IW'(s_raw - SW'(m_r));
    end else begin
      r_nxt = IW'(s_raw);
    end
  end

  assign i_inc      = i_r + CW'(1);
  assign probe_addr = AW'(r_r >> BYTE_SHIFT);
  assign bit_mask   = 8'(1) << r_r[BIT_SEL_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m_r    <= m_eff;
      n_r    <= n_eff;
      op_r   <= in_op;
      a_r    <= in_hash_a;
      b_r    <= in_hash_b;
      pres_r <= 1'b1;
    end
    if (cmd.setup) begin
      r_r <= am;
      c_r <= c_nxt;
      h_r <= a_r;
      i_r <= '0;
    end
    if (cmd.chk) begin
      r_r <= r_nxt;
      h_r <= hsum[HASH_W-1:0];
      i_r <= i_inc;
      if (!op_r && !rd_data_r[r_r[BIT_SEL_W-1:0]]) begin
        pres_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r  <= '0;
      clr_addr_r <= '0;
    end else begin
      if (cmd.load) begin
        div_cnt_r <= '0;
      end else if (cmd.div_step) begin
        div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
      end
      if (cmd.clr_wr) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
    end
  end

  // byte store: one write port, one registered read port
  assign mem_we    = cmd.clr_wr || (cmd.chk && op_r);
  assign mem_waddr = cmd.clr_wr ? clr_addr_r : probe_addr;
  assign mem_wdata = cmd.clr_wr ? 8'h00 : (rd_data_r | bit_mask);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_data_r <= mem[probe_addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_set) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_set) begin
      out_data_r <= pres_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W-1)'(0), out_data_r};

  assign sts.clr_last   = (clr_addr_r == AW'(STORE_BYTES - 1));
  assign sts.div_last   = (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1));
  assign sts.n_zero     = (n_r == '0);
  assign sts.probe_last = (i_inc == n_r);
  assign sts.bit_set    = rd_data_r[r_r[BIT_SEL_W-1:0]];
  assign sts.op_add     = op_r;
  assign sts.out_free   = !out_valid_r || out_tready;

  a_index_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |-> (MW'(r_r) < m_r))
    else $error("probe index not below modulus");

  a_no_result_overrun : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_set |-> (!out_valid_r || out_tready))
    else $error("result register overwritten before it was taken");

endmodule

FILE: sv/bfdh_ctrl.sv
// Controller: sequences store clear, remainder steps, probes and result hand-off.
module bfdh_ctrl
  import bfdh_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  dp_sts_t   sts,
  output ctrl_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        if (!sts.n_zero) begin
          state_nxt = ST_READ;
        end else if (sts.op_add) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_RESULT;
        end
      end
      ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.chk = 1'b1;
        if (!sts.op_add && !sts.bit_set) begin
          state_nxt = ST_RESULT;
        end else if (!sts.probe_last) begin
          state_nxt = ST_READ;
        end else if (sts.op_add) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (sts.out_free) begin
          cmd.out_set = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_add_no_result : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK && sts.op_add) |=> (state_r != ST_RESULT))
    else $error("add request headed for a result");

  a_setup_after_div : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SETUP) |-> ($past(state_r) == ST_DIV && $past(sts.div_last)))
    else $error("setup entered before remainders finished");

endmodule

FILE: sv/bloom_filter_double_hash_top.sv
// Top level of the double-hash Bloom filter engine: config registers and wiring.
//
//  channel | ports            | payload
//  --------+------------------+-----------------------------------------------
//  input   | in_t*            | tuser: op; tdata: hash_a [31:0], hash_b [63:32]
//  result  | out_t*           | tdata: present [0], zero fill [7:1]
//  config  | cfg_p* (APB)     | 0x0 bit_len (17b), 0x4 hash_count (5b)
//
//  Sequence: a request is taken in idle, then the remainder steps, a setup step and
//  k probes (k = hash_count, fewer for a test that hits a clear bit early), then a
//  result step for a test. The remainder steps run the bit-serial unit (hash_a,
//  hash_b, 2^32-1 mod m); a probe reads a store byte, then checks or sets its bit.
//  Reset: the byte store is swept to zero, one byte a cycle, over all FILTER_BITS/8
//  bytes; in_tready stays low until then, config writes are taken.
//  Stalls: the result register lets the next request in while present waits.
module bloom_filter_double_hash_top
  import bfdh_pkg::*;
#(
  parameter int FILTER_BITS = 65536,
  parameter int MAX_HASHES  = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input requests
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [31:0] hash_a, [63:32] hash_b
  input  logic                   in_tuser,   // [0] op (0 test, 1 add)
  // results (tests only)
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [0] present, [7:1] zero
  // configuration
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [CFG_DATA_W-1:0]  cfg_prdata,
  output logic                   cfg_pready
);

  logic [BIT_LEN_W-1:0]    bit_len_r;
  logic [HASH_COUNT_W-1:0] hash_count_r;
  logic                    cfg_wr;
  reg_idx_t                cfg_idx;
  ctrl_cmd_t               cmd;
  dp_sts_t                 sts;

  // ---- configuration registers; word index comes from paddr[2]
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_len_r    <= BIT_LEN_RST;
      hash_count_r <= HASH_COUNT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_BIT_LEN:    bit_len_r    <= cfg_pwdata[BIT_LEN_W-1:0];
        REG_HASH_COUNT: hash_count_r <= cfg_pwdata[HASH_COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_BIT_LEN:    cfg_prdata = CFG_DATA_W'(bit_len_r);
      REG_HASH_COUNT: cfg_prdata = CFG_DATA_W'(hash_count_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // ---- sequencing
  bfdh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // ---- index arithmetic, bit store, result register
  bfdh_datapath #(
    .FILTER_BITS(FILTER_BITS),
    .MAX_HASHES (MAX_HASHES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .bit_len   (bit_len_r),
    .hash_count(hash_count_r),
    .in_op     (in_tuser),
    .in_hash_a (in_tdata[HASH_W-1:0]),
    .in_hash_b (in_tdata[IN_TDATA_W-1:HASH_W]),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

endmodule
